@@ sv/isms_pkg.sv @@
`default_nettype none
package isms_pkg;

	localparam int WAIT_COUNT_BITS = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CMD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONV_WAIT   = 3'd4;

	localparam logic [7:0]  RST_DEVICE_ADDR = 8'd128;
	localparam logic [7:0]  RST_TEMP_CMD    = 8'd227;
	localparam logic [15:0] RST_HALF_PERIOD = 16'd250;
	localparam logic [7:0]  RST_POLL_LIMIT  = 8'd200;
	localparam logic [23:0] RST_CONV_WAIT   = 24'd100000;

	// value = (raw * GAIN) / 65536 - OFFSET, truncated toward zero
	localparam logic [14:0] TEMP_GAIN   = 15'd17572;
	localparam logic [14:0] TEMP_OFFSET = 15'd4685;
	localparam logic [14:0] HUM_GAIN    = 15'd12500;
	localparam logic [14:0] HUM_OFFSET  = 15'd600;

	localparam logic [1:0] ST_OK = 2'd0;

	typedef struct packed {
		logic        scl;
		logic        sda;
		logic        busy;
		logic        done;
		logic [1:0]  status;
		logic [15:0] raw;
		logic [7:0]  crc;
		logic        is_temp;
	} bus_res_t;

endpackage
`default_nettype wire

@@ sv/isms_ifaces.sv @@
`default_nettype none
interface isms_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] measure_cmd;
	logic       sda_in;

	modport source (output valid, output cmd, output measure_cmd, output sda_in, input ready);
	modport sink (input valid, input cmd, input measure_cmd, input sda_in, output ready);
endinterface

interface isms_out_if;
	logic               valid;
	logic               ready;
	logic               scl_out;
	logic               sda_out;
	logic               busy_res;
	logic               done_res;
	logic [1:0]         status;
	logic [15:0]        raw_value;
	logic [7:0]         crc_byte;
	logic               is_temperature;
	logic signed [14:0] converted_value;

	modport source (output valid, output scl_out, output sda_out, output busy_res,
		output done_res, output status, output raw_value, output crc_byte,
		output is_temperature, output converted_value, input ready);
	modport sink (input valid, input scl_out, input sda_out, input busy_res,
		input done_res, input status, input raw_value, input crc_byte,
		input is_temperature, input converted_value, output ready);
endinterface
`default_nettype wire

@@ sv/i2c_sensor_measure_sequencer.sv @@
// A tick transfer's result is registered in the bus FSM, the multiply stage
// and the output register, in that order. Throughput: one tick per cycle
// unless the output stalls; each stage holds while the next is full and stalled.
// Reset (arst_n low): registers to their defaults, bus idle with SCL and SDA
// released, stores cleared, no result pending.
`default_nettype none
module i2c_sensor_measure_sequencer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [isms_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [isms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	isms_in_if.sink                               tick,
	isms_out_if.source                            result
);

	logic               res_valid, res_ready;
	isms_pkg::bus_res_t res;

	isms_bus_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.tick      (tick),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	isms_conv_pipe u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.result    (result)
	);

endmodule
`default_nettype wire

@@ sv/isms_bus_fsm.sv @@
`default_nettype none
module isms_bus_fsm (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [isms_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [isms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	isms_in_if.sink                               tick,
	output logic                                  res_valid,
	input  wire logic                             res_ready,
	output isms_pkg::bus_res_t                    res
);

	localparam int CNT_W = isms_pkg::WAIT_COUNT_BITS;

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_TX, PH_ACKP, PH_POLL, PH_ACKEND,
		PH_WAIT, PH_RX, PH_MACK, PH_NSTOP
	} phase_t;

	logic [7:0]  dev_addr_q, temp_cmd_q, poll_limit_q;
	logic [15:0] half_q;
	logic [23:0] conv_wait_q;

	phase_t             phase_q, phase_n;
	logic [3:0]         sub_q, sub_n, sub_inc;
	logic [CNT_W-1:0]   tick_q, tick_n, half_m1, wait_w, wait_m1;
	logic               scl_q, scl_n, sda_q, sda_n, done_q, done_n;
	logic [7:0]         shift_q, shift_n, rx_shift, tx_byte;
	logic [1:0]         bidx_q, bidx_n;
	logic [7:0]         poll_q, poll_n, poll_inc;
	logic [7:0]         saved_q, saved_n, check_q, check_n;
	logic [15:0]        word_q, word_n;
	logic [1:0]         status_q, status_n, nack_code;
	logic               accept;

	assign accept     = tick.valid && tick.ready;
	assign tick.ready = !res_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q   <= isms_pkg::RST_DEVICE_ADDR;
			temp_cmd_q   <= isms_pkg::RST_TEMP_CMD;
			half_q       <= isms_pkg::RST_HALF_PERIOD;
			poll_limit_q <= isms_pkg::RST_POLL_LIMIT;
			conv_wait_q  <= isms_pkg::RST_CONV_WAIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				isms_pkg::REG_DEVICE_ADDR: dev_addr_q   <= cfg_wdata[7:0];
				isms_pkg::REG_TEMP_CMD:    temp_cmd_q   <= cfg_wdata[7:0];
				isms_pkg::REG_HALF_PERIOD: half_q       <= cfg_wdata[15:0];
				isms_pkg::REG_POLL_LIMIT:  poll_limit_q <= cfg_wdata[7:0];
				isms_pkg::REG_CONV_WAIT:   conv_wait_q  <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	assign half_m1   = (half_q == '0) ? '0 : CNT_W'(half_q - 16'd1);
	assign wait_w    = CNT_W'(conv_wait_q);
	assign wait_m1   = (wait_w == '0) ? '0 : wait_w - CNT_W'(1);
	assign sub_inc   = sub_q + 4'd1;
	assign poll_inc  = poll_q + 8'd1;
	assign rx_shift  = sub_q[0] ? {shift_q[6:0], tick.sda_in} : shift_q;
	assign nack_code = bidx_q + 2'd1;
	assign tx_byte   = (bidx_q == 2'd2) ? dev_addr_q + 8'd1 : dev_addr_q;

	always_comb begin
		phase_n  = phase_q;
		sub_n    = sub_q;
		tick_n   = tick_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		shift_n  = shift_q;
		bidx_n   = bidx_q;
		poll_n   = poll_q;
		saved_n  = saved_q;
		word_n   = word_q;
		check_n  = check_q;
		status_n = status_q;
		done_n   = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (tick.cmd) begin
				saved_n  = tick.measure_cmd;
				word_n   = '0;
				check_n  = '0;
				status_n = isms_pkg::ST_OK;
				bidx_n   = '0;
				poll_n   = '0;
				shift_n  = '0;
				tick_n   = half_m1;
				{phase_n, sub_n, sda_n} = {PH_START, 4'd0, 1'b1};
			end
		end else if (tick_q != '0) begin
			tick_n = tick_q - CNT_W'(1);
		end else begin
			tick_n = half_m1;
			case (phase_q)
				PH_START: begin
					case (sub_q)
						4'd0: {phase_n, sub_n, scl_n, sda_n} = {PH_START, 4'd1, 1'b1, 1'b1};
						4'd1: {phase_n, sub_n, scl_n, sda_n} = {PH_START, 4'd2, 1'b1, 1'b0};
						4'd2: {phase_n, sub_n, scl_n, sda_n} = {PH_START, 4'd3, 1'b0, 1'b0};
						default: begin
							shift_n = tx_byte;
							{phase_n, sub_n, scl_n, sda_n} = {PH_TX, 4'd0, 1'b0, tx_byte[7]};
						end
					endcase
				end
				PH_TX: begin
					if (sub_q != 4'd15) begin
						{phase_n, sub_n, scl_n} = {PH_TX, sub_inc, sub_inc[0]};
						sda_n = shift_q[3'd7 - sub_inc[3:1]];
					end else begin
						{phase_n, sub_n, scl_n} = {PH_ACKP, 4'd0, 1'b1};
					end
				end
				PH_ACKP: begin
					case (sub_q)
						4'd0: {phase_n, sub_n, scl_n, sda_n} = {PH_ACKP, 4'd1, 1'b0, 1'b1};
						4'd1: {phase_n, sub_n, scl_n, sda_n} = {PH_ACKP, 4'd2, 1'b0, 1'b1};
						4'd2: {phase_n, sub_n, scl_n, sda_n} = {PH_ACKP, 4'd3, 1'b1, 1'b1};
						default: begin
							poll_n = '0;
							if (poll_limit_q == '0) begin
								status_n = nack_code;
								{phase_n, sub_n, scl_n, sda_n} = {PH_ACKEND, 4'd0, 1'b0, 1'b1};
							end else begin
								{phase_n, sub_n, scl_n, sda_n} = {PH_POLL, 4'd0, 1'b1, 1'b1};
							end
						end
					endcase
				end
				PH_POLL: begin
					if (!tick.sda_in) begin
						{phase_n, sub_n, scl_n, sda_n} = {PH_ACKEND, 4'd0, 1'b0, 1'b1};
					end else begin
						poll_n = poll_inc;
						if (poll_inc >= poll_limit_q) begin
							status_n = nack_code;
							{phase_n, sub_n, scl_n, sda_n} = {PH_ACKEND, 4'd0, 1'b0, 1'b1};
						end else begin
							{phase_n, sub_n, scl_n, sda_n} = {PH_POLL, 4'd0, 1'b1, 1'b1};
						end
					end
				end
				PH_ACKEND: begin
					if (status_q != isms_pkg::ST_OK) begin
						{phase_n, sub_n, tick_n, scl_n, sda_n} = {PH_IDLE, 4'd0, CNT_W'(0), 2'b11};
						done_n = 1'b1;
					end else if (bidx_q == 2'd0) begin
						bidx_n  = 2'd1;
						shift_n = saved_q;
						{phase_n, sub_n, scl_n, sda_n} = {PH_TX, 4'd0, 1'b0, saved_q[7]};
					end else if (bidx_q == 2'd1) begin
						tick_n = wait_m1;
						{phase_n, sub_n, scl_n, sda_n} = {PH_WAIT, 4'd0, 1'b0, 1'b1};
					end else begin
						bidx_n  = 2'd0;
						shift_n = '0;
						{phase_n, sub_n, scl_n, sda_n} = {PH_RX, 4'd0, 1'b0, 1'b1};
					end
				end
				PH_WAIT: begin
					bidx_n = 2'd2;
					{phase_n, sub_n, sda_n} = {PH_START, 4'd0, 1'b1};
				end
				PH_RX: begin
					shift_n = rx_shift;
					if (sub_q != 4'd15) begin
						{phase_n, sub_n, scl_n, sda_n} = {PH_RX, sub_inc, sub_inc[0], 1'b1};
					end else if (bidx_q == 2'd0) begin
						word_n = {rx_shift, word_q[7:0]};
						{phase_n, sub_n, scl_n, sda_n} = {PH_MACK, 4'd0, 1'b0, 1'b0};
					end else if (bidx_q == 2'd1) begin
						word_n = {word_q[15:8], rx_shift};
						{phase_n, sub_n, scl_n, sda_n} = {PH_MACK, 4'd0, 1'b0, 1'b0};
					end else begin
						check_n = rx_shift;
						{phase_n, sub_n, scl_n, sda_n} = {PH_NSTOP, 4'd0, 1'b0, 1'b1};
					end
				end
				PH_MACK: begin
					case (sub_q)
						4'd0: {phase_n, sub_n, scl_n, sda_n} = {PH_MACK, 4'd1, 1'b0, 1'b0};
						4'd1: {phase_n, sub_n, scl_n, sda_n} = {PH_MACK, 4'd2, 1'b1, 1'b0};
						4'd2: {phase_n, sub_n, scl_n, sda_n} = {PH_MACK, 4'd3, 1'b0, 1'b0};
						4'd3: {phase_n, sub_n, scl_n, sda_n} = {PH_MACK, 4'd4, 1'b0, 1'b1};
						default: begin
							bidx_n  = bidx_q + 2'd1;
							shift_n = '0;
							{phase_n, sub_n, scl_n, sda_n} = {PH_RX, 4'd0, 1'b0, 1'b1};
						end
					endcase
				end
				PH_NSTOP: begin
					case (sub_q)
						4'd0: {phase_n, sub_n, scl_n, sda_n} = {PH_NSTOP, 4'd1, 1'b1, 1'b1};
						4'd1: {phase_n, sub_n, scl_n, sda_n} = {PH_NSTOP, 4'd2, 1'b0, 1'b0};
						4'd2: {phase_n, sub_n, scl_n, sda_n} = {PH_NSTOP, 4'd3, 1'b1, 1'b0};
						4'd3: {phase_n, sub_n, scl_n, sda_n} = {PH_NSTOP, 4'd4, 1'b1, 1'b1};
						default: begin
							{phase_n, sub_n, tick_n, scl_n, sda_n} =
								{PH_IDLE, 4'd0, CNT_W'(0), 2'b11};
							done_n = 1'b1;
						end
					endcase
				end
				default: begin
					{phase_n, sub_n, tick_n, scl_n, sda_n} = {PH_IDLE, 4'd0, CNT_W'(0), 2'b11};
					done_n = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sub_q     <= '0;
			tick_q    <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			done_q    <= 1'b0;
			shift_q   <= '0;
			bidx_q    <= '0;
			poll_q    <= '0;
			saved_q   <= '0;
			word_q    <= '0;
			check_q   <= '0;
			status_q  <= isms_pkg::ST_OK;
			res_valid <= 1'b0;
		end else begin
			if (accept) begin
				phase_q  <= phase_n;
				sub_q    <= sub_n;
				tick_q   <= tick_n;
				scl_q    <= scl_n;
				sda_q    <= sda_n;
				done_q   <= done_n;
				shift_q  <= shift_n;
				bidx_q   <= bidx_n;
				poll_q   <= poll_n;
				saved_q  <= saved_n;
				word_q   <= word_n;
				check_q  <= check_n;
				status_q <= status_n;
			end
			if (accept)
				res_valid <= 1'b1;
			else if (res_ready)
				res_valid <= 1'b0;
		end
	end

	assign res.scl     = scl_q;
	assign res.sda     = sda_q;
	assign res.busy    = (phase_q != PH_IDLE);
	assign res.done    = done_q;
	assign res.status  = status_q;
	assign res.raw     = word_q;
	assign res.crc     = check_q;
	assign res.is_temp = (saved_q == temp_cmd_q);

endmodule
`default_nettype wire

@@ sv/isms_conv_pipe.sv @@
`default_nettype none
module isms_conv_pipe (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	output logic                    res_ready,
	input  wire isms_pkg::bus_res_t res,
	isms_out_if.source              result
);

	logic               v_s2, v_s3, rdy_s2, rdy_s3;
	isms_pkg::bus_res_t fld_s2, fld_s3;
	logic [30:0]        prod_c, prod_s2;
	logic [14:0]        gain, offs, hi;
	logic [15:0]        diff, quot;
	logic               corr;
	logic signed [14:0] conv_c, conv_s3;

	assign rdy_s3    = !v_s3 || result.ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign res_ready = rdy_s2;

	assign gain   = res.is_temp ? isms_pkg::TEMP_GAIN : isms_pkg::HUM_GAIN;
	assign prod_c = {15'd0, res.raw} * {16'd0, gain};

	// low 16 bits of the offset are zero, so truncation toward zero only
	// needs a round-up when the result is negative and the fraction nonzero
	assign offs   = fld_s2.is_temp ? isms_pkg::TEMP_OFFSET : isms_pkg::HUM_OFFSET;
	assign hi     = prod_s2[30:16];
	assign diff   = {1'b0, hi} - {1'b0, offs};
	assign corr   = (hi < offs) && (prod_s2[15:0] != '0);
	assign quot   = diff + {15'd0, corr};
	assign conv_c = (fld_s2.status != isms_pkg::ST_OK) ? '0 : quot[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2)
				v_s2 <= res_valid;
			if (rdy_s3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && res_valid) begin
			fld_s2  <= res;
			prod_s2 <= prod_c;
		end
		if (rdy_s3 && v_s2) begin
			fld_s3  <= fld_s2;
			conv_s3 <= conv_c;
		end
	end

	assign result.valid           = v_s3;
	assign result.scl_out         = fld_s3.scl;
	assign result.sda_out         = fld_s3.sda;
	assign result.busy_res        = fld_s3.busy;
	assign result.done_res        = fld_s3.done;
	assign result.status          = fld_s3.status;
	assign result.raw_value       = fld_s3.raw;
	assign result.crc_byte        = fld_s3.crc;
	assign result.is_temperature  = fld_s3.is_temp;
	assign result.converted_value = conv_s3;

endmodule
`default_nettype wire

@@ sv/isms_checker.sv @@
`default_nettype none
module isms_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               scl_out,
	input wire logic               sda_out,
	input wire logic               busy_res,
	input wire logic               done_res,
	input wire logic [1:0]         status,
	input wire logic [15:0]        raw_value,
	input wire logic [7:0]         crc_byte,
	input wire logic signed [14:0] converted_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl_out && sda_out)
		else $error("lines driven while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done while busy");

	a_nack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != isms_pkg::ST_OK |->
			converted_value == '0 && raw_value == '0 && crc_byte == '0)
		else $error("data present after nack");

endmodule

bind i2c_sensor_measure_sequencer isms_checker u_isms_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.scl_out         (result.scl_out),
	.sda_out         (result.sda_out),
	.busy_res        (result.busy_res),
	.done_res        (result.done_res),
	.status          (result.status),
	.raw_value       (result.raw_value),
	.crc_byte        (result.crc_byte),
	.converted_value (result.converted_value)
);
`default_nettype wire
